// ===== src/indexed_doubly_linked_list_defines.svh =====
// assertion macros for the indexed doubly linked list
`ifndef INDEXED_DOUBLY_LINKED_LIST_DEFINES_SVH
`define INDEXED_DOUBLY_LINKED_LIST_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked at every rising edge outside reset
`define IDLL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("idll check failed");
// implication whose consequent is checked in the next cycle
`define IDLL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("idll check failed");
`else
`define IDLL_ASSERT_NOW(label, ante, cons)
`define IDLL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/idll_pkg.sv =====
// shared types and constants for the indexed doubly linked list
`timescale 1ns / 1ps

package idll_pkg;

  localparam int NODES_DEFAULT = 1023;
  localparam int LINK_W        = 10;
  localparam int CMD_W         = 2;
  localparam int DATA_W        = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_REMOVE     = 2'd0,
    CMD_INS_BEFORE = 2'd1,
    CMD_INS_AFTER  = 2'd2,
    CMD_QUERY      = 2'd3
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic slot1;
    logic slot2;
    logic out_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic out_free;
  } stat_t;

endpackage

// ===== src/idll_ctrl.sv =====
// command sequencer for the indexed doubly linked list
`timescale 1ns / 1ps

module idll_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  idll_pkg::stat_t stat,
  output idll_pkg::ctrl_t ctrl
);
  import idll_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_W1    = 4'b0100,
    ST_W2    = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    ctrl          = '0;
    case (state)
      ST_CLEAR: begin
        ctrl.clear = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ctrl.accept = 1'b1;
          state_next  = ST_W1;
        end
      end
      ST_W1: begin
        if (stat.is_query) begin
          // wait for room in the output register
          if (stat.out_free) begin
            ctrl.out_load = 1'b1;
            state_next    = ST_IDLE;
          end
        end else begin
          ctrl.slot1 = 1'b1;
          state_next = ST_W2;
        end
      end
      ST_W2: begin
        ctrl.slot2 = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/idll_dp.sv =====
// link memories, request registers and result register
`timescale 1ns / 1ps

module idll_dp #(
  parameter int NODES = idll_pkg::NODES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  idll_pkg::ctrl_t             ctrl,
  output idll_pkg::stat_t             stat,
  input  logic [idll_pkg::DATA_W-1:0] in_data,
  input  logic [idll_pkg::CMD_W-1:0]  in_user,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [idll_pkg::DATA_W-1:0] out_data
);
  import idll_pkg::*;

  localparam int DEPTH = NODES + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [16:0] NODES_U = 17'(NODES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [LINK_W-1:0] prev_mem [DEPTH];
  logic [LINK_W-1:0] next_mem [DEPTH];

  cmd_t              cmd_q;
  logic [LINK_W-1:0] node_q;
  logic [LINK_W-1:0] new_q;
  logic [LINK_W-1:0] prev_rd;
  logic [LINK_W-1:0] next_rd;
  logic [AW-1:0]     clr_addr;
  logic [LINK_W-1:0] out_prev;
  logic [LINK_W-1:0] out_next;

  logic [LINK_W-1:0] in_node;
  logic [LINK_W-1:0] in_new;
  logic [AW-1:0]     rd_addr;

  logic              node_ok;
  logic              new_ok;
  logic              p_ok;
  logic              x_ok;
  logic              act;

  logic              pw_en;
  logic [LINK_W-1:0] pw_link;
  logic [LINK_W-1:0] pw_data;
  logic [AW-1:0]     pw_addr;
  logic              nw_en;
  logic [LINK_W-1:0] nw_link;
  logic [LINK_W-1:0] nw_data;
  logic [AW-1:0]     nw_addr;

  function automatic logic in_range(logic [LINK_W-1:0] v);
    return (v != '0) && (17'(v) <= NODES_U);
  endfunction

  assign in_node = in_data[LINK_W-1:0];
  assign in_new  = in_data[2*LINK_W-1:LINK_W];
  assign rd_addr = AW'(in_node);

  // request registers
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_q  <= cmd_t'(in_user);
      node_q <= in_node;
      new_q  <= in_new;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctrl.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign node_ok = in_range(node_q);
  assign new_ok  = in_range(new_q) && (new_q != node_q);
  assign p_ok    = in_range(prev_rd);
  assign x_ok    = in_range(next_rd);

  always_comb begin
    case (cmd_q)
      CMD_REMOVE:     act = node_ok;
      CMD_INS_BEFORE: act = node_ok && new_ok;
      CMD_INS_AFTER:  act = node_ok && new_ok;
      default:        act = 1'b0;
    endcase
  end

  // two write slots per memory, in the order the list update needs
  always_comb begin
    pw_en   = 1'b0;
    pw_link = node_q;
    pw_data = '0;
    nw_en   = 1'b0;
    nw_link = node_q;
    nw_data = '0;
    if (ctrl.slot1 && act) begin
      case (cmd_q)
        CMD_REMOVE: begin
          nw_en   = p_ok;
          nw_link = prev_rd;
          nw_data = next_rd;
          pw_en   = x_ok;
          pw_link = next_rd;
          pw_data = prev_rd;
        end
        CMD_INS_BEFORE: begin
          nw_en   = p_ok;
          nw_link = prev_rd;
          nw_data = new_q;
          pw_en   = 1'b1;
          pw_link = node_q;
          pw_data = new_q;
        end
        CMD_INS_AFTER: begin
          pw_en   = x_ok;
          pw_link = next_rd;
          pw_data = new_q;
          nw_en   = 1'b1;
          nw_link = node_q;
          nw_data = new_q;
        end
        default: begin
          pw_en = 1'b0;
        end
      endcase
    end else if (ctrl.slot2 && act) begin
      case (cmd_q)
        CMD_REMOVE: begin
          pw_en   = 1'b1;
          pw_link = node_q;
          pw_data = '0;
          nw_en   = 1'b1;
          nw_link = node_q;
          nw_data = '0;
        end
        CMD_INS_BEFORE: begin
          pw_en   = 1'b1;
          pw_link = new_q;
          pw_data = prev_rd;
          nw_en   = 1'b1;
          nw_link = new_q;
          nw_data = node_q;
        end
        CMD_INS_AFTER: begin
          pw_en   = 1'b1;
          pw_link = new_q;
          pw_data = node_q;
          nw_en   = 1'b1;
          nw_link = new_q;
          nw_data = next_rd;
        end
        default: begin
          pw_en = 1'b0;
        end
      endcase
    end else if (ctrl.clear) begin
      pw_en = 1'b1;
      nw_en = 1'b1;
    end
  end

  assign pw_addr = ctrl.clear ? clr_addr : AW'(pw_link);
  assign nw_addr = ctrl.clear ? clr_addr : AW'(nw_link);

  always_ff @(posedge clk) begin
    if (pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    if (ctrl.accept) begin
      prev_rd <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    if (ctrl.accept) begin
      next_rd <= next_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_prev <= node_ok ? prev_rd : '0;
      out_next <= node_ok ? next_rd : '0;
    end
  end

  assign out_data = {(DATA_W - 2*LINK_W)'(0), out_next, out_prev};

  assign stat.clr_last = (clr_addr == LAST_ADDR);
  assign stat.is_query = (cmd_q == CMD_QUERY);
  assign stat.out_free = !out_valid || out_ready;

endmodule

// ===== src/indexed_doubly_linked_list.sv =====
// query: result register loaded in W1 once it has room; a new request is taken only back in idle
// remove and insert: write slots W1 then W2, up to two writes into each single-port link memory
// link memories are read once per request, on the cycle it is accepted
// after rst a clearing pass zeroes every link; no requests are taken during it
`timescale 1ns / 1ps
`include "indexed_doubly_linked_list_defines.svh"

module indexed_doubly_linked_list #(
  parameter int NODES = idll_pkg::NODES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [9:0] node, [19:10] new_node, [23:20] zero
  input  logic [idll_pkg::DATA_W-1:0] s_axis_tdata,
  // [1:0] command
  input  logic [idll_pkg::CMD_W-1:0]  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [9:0] prev_link, [19:10] next_link, [23:20] zero
  output logic [idll_pkg::DATA_W-1:0] m_axis_tdata
);
  import idll_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  idll_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .ctrl          (ctrl)
  );

  idll_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  `IDLL_ASSERT_NOW(a_no_req_in_clear, ctrl.clear, !s_axis_tready)
  `IDLL_ASSERT_NOW(a_load_needs_room, ctrl.out_load, !m_axis_tvalid || m_axis_tready)
  `IDLL_ASSERT_NEXT(a_one_at_a_time, ctrl.accept, !s_axis_tready)
  `IDLL_ASSERT_NEXT(a_load_shows, ctrl.out_load, m_axis_tvalid)

endmodule

// ===== tb/tb_indexed_doubly_linked_list.sv =====
// self-checking testbench for the indexed doubly linked list, with a link table tracker
`timescale 1ns / 1ps

module tb_indexed_doubly_linked_list;
  import idll_pkg::*;

  localparam int NODES          = NODES_DEFAULT;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [LINK_W-1:0] prev_link;
    logic [LINK_W-1:0] next_link;
  } link_pair_t;

  // mirrors both link memories and queues the answers owed to queries
  class link_table_tracker;
    bit [LINK_W-1:0] prev_tab [0:NODES];
    bit [LINK_W-1:0] next_tab [0:NODES];
    link_pair_t      pending_links [$];
    int              errors;
    int              requests;
    int              queries;
    int              inserts;
    int              removes;

    function bit is_linked(int n);
      return prev_tab[n] != 0 || next_tab[n] != 0;
    endfunction

    function void note_request(cmd_t c, logic [LINK_W-1:0] n, logic [LINK_W-1:0] k);
      bit [LINK_W-1:0] p;
      bit [LINK_W-1:0] x;
      link_pair_t      lp;
      bit              n_ok;
      n_ok = n != 0 && n <= NODES;
      requests++;
      if (c == CMD_QUERY) begin
        lp = '0;
        if (n_ok) begin
          lp.prev_link = prev_tab[n];
          lp.next_link = next_tab[n];
        end
        pending_links.push_back(lp);
        queries++;
        return;
      end
      if (!n_ok) return;
      p = prev_tab[n];
      x = next_tab[n];
      if (c == CMD_REMOVE) begin
        // join the neighbours, skipping a missing one
        if (p != 0) next_tab[p] = x;
        if (x != 0) prev_tab[x] = p;
        prev_tab[n] = 0;
        next_tab[n] = 0;
        removes++;
        return;
      end
      if (k == 0 || k > NODES || k == n) return;
      if (c == CMD_INS_BEFORE) begin
        if (p != 0) next_tab[p] = k;
        prev_tab[n] = k;
        prev_tab[k] = p;
        next_tab[k] = n;
      end else begin
        if (x != 0) prev_tab[x] = k;
        next_tab[n] = k;
        prev_tab[k] = n;
        next_tab[k] = x;
      end
      inserts++;
    endfunction

    function void check_links(logic [DATA_W-1:0] d);
      link_pair_t exp_pair;
      if (pending_links.size() == 0) begin
        errors++;
        $display("%0t: result with no query waiting: expected none, actual prev %0d next %0d",
                 $time, d[LINK_W-1:0], d[2*LINK_W-1:LINK_W]);
        return;
      end
      exp_pair = pending_links.pop_front();
      if (d[LINK_W-1:0] !== exp_pair.prev_link) begin
        errors++;
        $display("%0t: prev_link expected %0d actual %0d",
                 $time, exp_pair.prev_link, d[LINK_W-1:0]);
      end
      if (d[2*LINK_W-1:LINK_W] !== exp_pair.next_link) begin
        errors++;
        $display("%0t: next_link expected %0d actual %0d",
                 $time, exp_pair.next_link, d[2*LINK_W-1:LINK_W]);
      end
    endfunction
  endclass

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // [9:0] node, [19:10] new_node, [23:20] zero
  logic [DATA_W-1:0] s_axis_tdata  = '0;
  // [1:0] command
  logic [CMD_W-1:0]  s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [9:0] prev_link, [19:10] next_link, [23:20] zero
  logic [DATA_W-1:0] m_axis_tdata;

  link_table_tracker book;
  bit                steady;
  int                hold_offs_asked;
  int                idle_cycles;

  indexed_doubly_linked_list #(.NODES(NODES)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_request(cmd_t c, int n, int k);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {{(DATA_W-2*LINK_W){1'b0}}, k[LINK_W-1:0], n[LINK_W-1:0]};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    book.note_request(c, n[LINK_W-1:0], k[LINK_W-1:0]);
  endtask

  // a few tries for a node in 1..hi that is (or is not) in a list
  function automatic int pick_node(int hi, bit want_linked);
    int cand;
    cand = 1;
    for (int t = 0; t < 8; t++) begin
      cand = $urandom_range(1, hi);
      if (book.is_linked(cand) == want_linked) return cand;
    end
    return cand;
  endfunction

  task automatic run_random(int count, int pool_hi, int query_pct);
    cmd_t c;
    int   n;
    int   k;
    int   r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise: anything the fields allow
        c = cmd_t'($urandom_range(0, 3));
        n = $urandom_range(0, 1023);
        k = $urandom_range(0, 1023);
      end else begin
        n = pick_node(pool_hi, 1'b1);
        k = pick_node(pool_hi, 1'b0);
        if (k == n) k = (n % pool_hi) + 1;
        r = $urandom_range(0, 99);
        if (r < query_pct) c = CMD_QUERY;
        else if (r < query_pct + (100 - query_pct) * 6 / 10) begin
          if ($urandom_range(0, 1) != 0) c = CMD_INS_BEFORE;
          else c = CMD_INS_AFTER;
        end else c = CMD_REMOVE;
      end
      send_request(c, n, k);
    end
  endtask

  task automatic run_directed();
    send_request(CMD_QUERY, 0, 0);
    send_request(CMD_QUERY, 1023, 0);
    send_request(CMD_REMOVE, 5, 0);
    send_request(CMD_REMOVE, 0, 0);
    send_request(CMD_INS_AFTER, 0, 7);
    send_request(CMD_INS_AFTER, 1, 0);
    send_request(CMD_INS_BEFORE, 1, 1);
    // build 2 - 1 - 341 - 1023 - 512
    send_request(CMD_INS_AFTER, 1, 1023);
    send_request(CMD_INS_BEFORE, 1, 2);
    send_request(CMD_INS_AFTER, 1023, 512);
    send_request(CMD_INS_BEFORE, 1023, 341);
    send_request(CMD_QUERY, 1, 0);
    send_request(CMD_QUERY, 1023, 0);
    send_request(CMD_QUERY, 341, 0);
    // middle, head, then tail
    send_request(CMD_REMOVE, 341, 0);
    send_request(CMD_REMOVE, 2, 0);
    send_request(CMD_REMOVE, 512, 0);
    send_request(CMD_QUERY, 1, 0);
    send_request(CMD_QUERY, 1023, 0);
    send_request(CMD_QUERY, 341, 0);
    send_request(CMD_INS_AFTER, 1023, 682);
    // new node already in a list gets its links overwritten
    send_request(CMD_INS_BEFORE, 682, 1);
    send_request(CMD_QUERY, 1, 0);
    send_request(CMD_QUERY, 682, 0);
    send_request(CMD_QUERY, 1023, 0);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_offs_done;
    stall_left     = 0;
    hold_offs_done = 0;
    forever begin
      if (hold_offs_done != hold_offs_asked) begin
        stall_left = HOLD_CYCLES;
        hold_offs_done++;
      end
      @(negedge clk);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        book.check_links(m_axis_tdata);
        stall_left = steady ? 0 : $urandom_range(0, 4);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("indexed_doubly_linked_list: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    book            = new();
    steady          = 1'b0;
    hold_offs_asked = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(300, 16, 35);
    run_random(200, 64, 35);
    steady = 1'b1;
    run_random(100, 64, 40);
    steady = 1'b0;
    // queries wait behind a stalled result side
    hold_offs_asked++;
    run_random(150, 32, 85);
    run_random(450, 1023, 30);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (book.pending_links.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (book.pending_links.size() != 0) begin
      book.errors++;
      $display("%0t: %0d query results never arrived", $time, book.pending_links.size());
    end
    $display("covered %0d requests: %0d queries answered, %0d inserts, %0d removes",
             book.requests, book.queries, book.inserts, book.removes);
    $display("list pools of 16 to 1023 nodes, steady and idling traffic, one long output stall");
    if (book.errors == 0) begin
      $display("indexed_doubly_linked_list: match");
    end else begin
      $display("indexed_doubly_linked_list: mismatch");
    end
    $finish;
  end

endmodule
